@@ design/ism_pkg.sv @@
// ----------------------------------------------------------------------------
// ism_pkg
// Shared widths, codes and payload types of the I/O segment interval merger.
// ----------------------------------------------------------------------------
package ism_pkg;

    localparam int FILE_W      = 16;
    localparam int OFFSET_BITS = 48;
    localparam int SIZE_W      = OFFSET_BITS + 1;
    localparam int END_W       = OFFSET_BITS + 2;
    localparam int STORE_DEPTH = 256;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_W     = FILE_W + OFFSET_BITS + SIZE_W;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POPPED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd5;

    typedef struct packed {
        logic [1:0]             kind;
        logic [FILE_W-1:0]      file_id;
        logic [OFFSET_BITS-1:0] seg_start;
        logic [OFFSET_BITS-1:0] seg_size;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [FILE_W-1:0]      out_file_id;
        logic [OFFSET_BITS-1:0] out_start;
        logic [SIZE_W-1:0]      out_size;
        logic [CNT_W-1:0]       entry_count;
    } t_out_item;

    typedef struct packed {
        logic [FILE_W-1:0]      file;
        logic [OFFSET_BITS-1:0] start;
        logic [SIZE_W-1:0]      size;
    } t_entry;

    typedef struct packed {
        logic load;
        logic absorb;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic absorb;
        logic out_free;
    } t_sts;

endpackage

@@ design/ism_if.sv @@
// ----------------------------------------------------------------------------
// ism_if
// Valid/ready channels for segment commands and merger results.
// ----------------------------------------------------------------------------
interface ism_in_if;
    import ism_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ism_out_if;
    import ism_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/ism_ram.sv @@
// ----------------------------------------------------------------------------
// ism_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ism_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ design/ism_ctrl.sv @@
// ----------------------------------------------------------------------------
// ism_ctrl
// Sequencer: accept a word, walk absorbed intervals, commit the result.
// ----------------------------------------------------------------------------
module ism_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_kind,
    input  ism_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output ism_pkg::t_cmd o_cmd
);
    import ism_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_kind == KIND_PUSH) ? S_CHECK : S_DONE;
                end
            end
            S_CHECK: begin
                if (i_sts.absorb) begin
                    o_cmd.absorb = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register can take the word
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ design/ism_datapath.sv @@
// ----------------------------------------------------------------------------
// ism_datapath
// Interval stack, group tracking, merge arithmetic and result register.
// ----------------------------------------------------------------------------
module ism_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ism_pkg::t_cmd      i_cmd,
    input  ism_pkg::t_in_item  i_in,
    input  logic               i_out_ready,
    output ism_pkg::t_sts      o_sts,
    output ism_pkg::t_out_item o_out,
    output logic               o_out_valid
);
    import ism_pkg::*;

    logic [1:0]             r_kind;
    logic [FILE_W-1:0]      r_fid;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_size;
    logic [SIZE_W-1:0]      r_reach;
    logic [OFFSET_BITS-1:0] r_lo;
    logic [END_W-1:0]       r_hi;
    logic                   r_merged;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_floor;
    logic [FILE_W-1:0]      r_cur_file;
    logic                   r_have_file;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       n_floor;
    t_out_item              n_out;

    logic [CNT_W-1:0]       w_rd_full;
    logic [IDX_W-1:0]       w_rd_addr;
    logic [ENTRY_W-1:0]     w_rd_data;
    t_entry                 w_top;
    logic [END_W-1:0]       w_top_end;
    logic [END_W-1:0]       w_mrg_size;
    logic [CNT_W-1:0]       w_count_dec;
    logic                   w_we;
    t_entry                 w_wr_entry;
    logic                   w_new_file;

    // track the stack top; while absorbing, fetch the entry beneath it
    assign w_rd_full = r_count - (i_cmd.absorb ? CNT_W'(2) : CNT_W'(1));
    assign w_rd_addr = w_rd_full[IDX_W-1:0];

    ism_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (w_wr_entry),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_top       = w_rd_data;
    assign w_top_end   = END_W'(w_top.start) + END_W'(w_top.size);
    assign w_mrg_size  = r_hi - END_W'(r_lo);
    assign w_count_dec = r_count - CNT_W'(1);
    assign w_new_file  = !r_have_file || (i_in.file_id != r_cur_file);

    assign o_sts.absorb   = (r_kind == KIND_PUSH) && (r_count > r_floor) &&
                            (SIZE_W'(w_top.start) <= r_reach);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out        = '0;
        n_out.status = ST_EMPTY;
        n_count      = r_count;
        n_floor      = r_floor;
        w_we         = 1'b0;
        w_wr_entry   = '{file: r_fid, start: r_start, size: SIZE_W'(r_size)};
        case (r_kind)
            KIND_PUSH: begin
                if (r_merged) begin
                    w_we             = i_cmd.commit;
                    w_wr_entry.start = r_lo;
                    w_wr_entry.size  = w_mrg_size[SIZE_W-1:0];
                    n_count          = r_count + CNT_W'(1);
                    n_out.status     = ST_MERGED;
                end else if (r_size == '0) begin
                    n_out.status = ST_ZERO;
                end else if (r_count >= CNT_W'(STORE_DEPTH)) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_we         = i_cmd.commit;
                    n_count      = r_count + CNT_W'(1);
                    n_out.status = ST_STORED;
                end
            end
            KIND_POP: begin
                if (r_count != '0) begin
                    n_count           = w_count_dec;
                    n_floor           = (r_floor > w_count_dec) ? w_count_dec : r_floor;
                    n_out.status      = ST_POPPED;
                    n_out.out_file_id = w_top.file;
                    n_out.out_start   = w_top.start;
                    n_out.out_size    = w_top.size;
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
                n_floor = '0;
            end
            default: begin
                n_out.status = ST_EMPTY;
            end
        endcase
        n_out.entry_count = n_count;
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in.kind;
            r_fid   <= i_in.file_id;
            r_start <= i_in.seg_start;
            r_size  <= i_in.seg_size;
            r_reach <= SIZE_W'(i_in.seg_start) + SIZE_W'(i_in.seg_size);
            r_lo    <= i_in.seg_start;
            r_hi    <= END_W'(i_in.seg_start) + END_W'(i_in.seg_size);
        end else if (i_cmd.absorb) begin
            if (w_top.start < r_lo) begin
                r_lo <= w_top.start;
            end
            if (w_top_end > r_hi) begin
                r_hi <= w_top_end;
            end
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // stack and group control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merged    <= 1'b0;
            r_count     <= '0;
            r_floor     <= '0;
            r_cur_file  <= '0;
            r_have_file <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_merged <= 1'b0;
                // a new file id freezes every interval stored so far
                if (i_in.kind == KIND_PUSH && w_new_file) begin
                    r_floor     <= r_count;
                    r_cur_file  <= i_in.file_id;
                    r_have_file <= 1'b1;
                end
            end else if (i_cmd.absorb) begin
                r_merged <= 1'b1;
                r_count  <= w_count_dec;
            end else if (i_cmd.commit) begin
                r_count <= n_count;
                r_floor <= n_floor;
                if (r_kind == KIND_CLEAR) begin
                    r_have_file <= 1'b0;
                end
            end

            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
endmodule

@@ design/io_segment_interval_merger_core.sv @@
// ----------------------------------------------------------------------------
// io_segment_interval_merger_core
// Coalesces (file id, start, size) segments into merged intervals on a stack.
// ----------------------------------------------------------------------------
// Push segments in descending order of file and start; a push that reaches the
// top interval of its file group absorbs it, and keeps absorbing downward.
// Every word gives one result word. A pop or clear is loaded, then committed;
// a push is loaded, absorbs intervals through the single read port of the
// 256-entry interval RAM (one entry fetched per cycle), then commits. A new
// word is accepted while the last result still waits in the output register.
module io_segment_interval_merger_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ism_in_if.sink           i_seg,
    ism_out_if.source        o_res
);
    import ism_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    logic      w_in_ready;
    t_out_item w_out;
    logic      w_out_valid;

    ism_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_seg.valid),
        .i_in_kind  (i_seg.data.kind),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    ism_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_seg.data),
        .i_out_ready (o_res.ready),
        .o_sts       (w_sts),
        .o_out       (w_out),
        .o_out_valid (w_out_valid)
    );

    assign i_seg.ready = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_out;
endmodule

@@ tb/sv/io_segment_interval_merger_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// io_segment_interval_merger_core_test
// Drives push, pop, clear and unused-kind words into the segment merger and
// mirrors its interval stack to predict each result word. Every result is
// compared field by field against the oldest prediction. The run includes
// directed corner cases, a fill of the store to overflow, random file groups,
// and a long output stall.
// ----------------------------------------------------------------------------
module io_segment_interval_merger_core_test;
    import ism_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Mirror of the interval stack; predicts one result word per command word.
    class interval_stack_mirror;
        t_entry            stack_mem [STORE_DEPTH];
        int unsigned       held;
        int unsigned       grp_floor;
        logic [FILE_W-1:0] cur_file;
        bit                file_seen;
        t_out_item         due_results [$];
        int unsigned       errors;

        function new();
            held      = 0;
            grp_floor = 0;
            cur_file  = '0;
            file_seen = 1'b0;
            errors    = 0;
        endfunction

        function void note_command(t_in_item w);
            t_out_item   r;
            t_entry      top;
            logic [63:0] lo, hi, reach, top_end, span;
            bit          merged;
            r = '0;
            case (w.kind)
                KIND_PUSH: begin
                    lo     = 64'(w.seg_start);
                    reach  = 64'(w.seg_start) + 64'(w.seg_size);
                    hi     = reach;
                    merged = 1'b0;
                    // a new file id freezes everything below
                    if (!file_seen || w.file_id != cur_file) begin
                        grp_floor = held;
                        cur_file  = w.file_id;
                        file_seen = 1'b1;
                    end
                    while (held > grp_floor && held > 0) begin
                        top = stack_mem[held - 1];
                        if (64'(top.start) > reach)
                            break;
                        top_end = 64'(top.start) + 64'(top.size);
                        if (64'(top.start) < lo)
                            lo = 64'(top.start);
                        if (top_end > hi)
                            hi = top_end;
                        held--;
                        merged = 1'b1;
                    end
                    if (merged) begin
                        span       = hi - lo;
                        top.file   = w.file_id;
                        top.start  = lo[OFFSET_BITS-1:0];
                        top.size   = span[SIZE_W-1:0];
                        stack_mem[held] = top;
                        held++;
                        r.status = ST_MERGED;
                    end else if (w.seg_size == '0) begin
                        r.status = ST_ZERO;
                    end else if (held >= STORE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        top.file  = w.file_id;
                        top.start = w.seg_start;
                        top.size  = SIZE_W'(w.seg_size);
                        stack_mem[held] = top;
                        held++;
                        r.status = ST_STORED;
                    end
                end
                KIND_POP: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        held--;
                        if (grp_floor > held)
                            grp_floor = held;
                        r.status      = ST_POPPED;
                        r.out_file_id = stack_mem[held].file;
                        r.out_start   = stack_mem[held].start;
                        r.out_size    = stack_mem[held].size;
                    end
                end
                KIND_CLEAR: begin
                    held      = 0;
                    grp_floor = 0;
                    file_seen = 1'b0;
                    r.status  = ST_EMPTY;
                end
                default: begin
                    r.status = ST_EMPTY;
                end
            endcase
            r.entry_count = CNT_W'(held);
            due_results.push_back(r);
        endfunction

        function void cmp_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result word, actual %h", $time, got);
                errors++;
            end else begin
                want = due_results.pop_front();
                cmp_field("status", want.status, got.status);
                cmp_field("out_file_id", want.out_file_id, got.out_file_id);
                cmp_field("out_start", want.out_start, got.out_start);
                cmp_field("out_size", want.out_size, got.out_size);
                cmp_field("entry_count", want.entry_count, got.entry_count);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ism_in_if  seg_ch ();
    ism_out_if res_ch ();

    io_segment_interval_merger_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch),
        .o_res   (res_ch)
    );

    interval_stack_mirror results;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_len;
    logic        rx_hold;

    logic [FILE_W-1:0] gen_file;
    logic [63:0]       gen_cursor;
    int unsigned       seq_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    // Long output hold-off, armed once by the stimulus.
    initial begin
        rx_hold = 1'b0;
        wait (hold_len != 0);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (hold_len) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && seg_ch.valid && seg_ch.ready)
            results.note_command(seg_ch.data);
        if (i_rst_n && res_ch.valid && res_ch.ready)
            results.check_result(res_ch.data);
    end

    function automatic logic [OFFSET_BITS-1:0] rand_off();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[OFFSET_BITS-1:0];
    endfunction

    function automatic t_in_item seg_word(logic [1:0] k, logic [FILE_W-1:0] f,
                                          logic [OFFSET_BITS-1:0] s,
                                          logic [OFFSET_BITS-1:0] z);
        t_in_item w;
        w.kind      = k;
        w.file_id   = f;
        w.seg_start = s;
        w.seg_size  = z;
        return w;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(t_in_item w);
        while ($urandom_range(99) < send_idle_pct) begin
            seg_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_ch.valid <= 1'b1;
        seg_ch.data  <= w;
        do @(posedge i_clk); while (!seg_ch.ready);
    endtask

    task automatic set_idling(int unsigned src_pct, int unsigned dst_pct);
        send_idle_pct = src_pct;
        stall_pct    <= dst_pct;
    endtask

    task automatic run_directed();
        logic [OFFSET_BITS-1:0] top_off;
        top_off = '1;
        send_word(seg_word(KIND_POP, 16'h0000, '0, '0));
        send_word(seg_word(KIND_UNUSED, 16'hFFFF, top_off, top_off));
        send_word(seg_word(KIND_CLEAR, 16'h0000, '0, '0));
        // widest span: both fields at their maximum, then absorbed from zero
        send_word(seg_word(KIND_PUSH, 16'hFFFF, top_off, top_off));
        send_word(seg_word(KIND_PUSH, 16'hFFFF, '0, top_off));
        send_word(seg_word(KIND_POP, 16'h0000, '0, '0));
        send_word(seg_word(KIND_PUSH, 16'h0000, '0, '0));
        send_word(seg_word(KIND_PUSH, 16'h1234, 48'd1000, 48'd100));
        send_word(seg_word(KIND_PUSH, 16'h1234, 48'd900, 48'd100));
        send_word(seg_word(KIND_PUSH, 16'h1234, 48'd500, 48'd0));
        send_word(seg_word(KIND_PUSH, 16'h1234, 48'd900, 48'd0));
        send_word(seg_word(KIND_PUSH, 16'h1234, 48'd700, 48'd50));
        send_word(seg_word(KIND_PUSH, 16'h1234, 48'd600, 48'd50));
        send_word(seg_word(KIND_PUSH, 16'h1234, 48'd100, 48'd900));
        // next file must not reach into the frozen group
        send_word(seg_word(KIND_PUSH, 16'h1233, 48'd1200, 48'd10));
        send_word(seg_word(KIND_PUSH, 16'h1233, 48'd1100, 48'd100));
        send_word(seg_word(KIND_PUSH, 16'h1233, 48'd50, 48'd2000));
        send_word(seg_word(KIND_PUSH, 16'h1000, 48'd0, 48'd5));
        send_word(seg_word(KIND_POP, 16'h0000, '0, '0));
        send_word(seg_word(KIND_POP, 16'h0000, '0, '0));
        send_word(seg_word(KIND_PUSH, 16'h1000, 48'd0, 48'd100000));
        send_word(seg_word(KIND_PUSH, 16'h1000, 48'd0, 48'd0));
        send_word(seg_word(KIND_CLEAR, 16'hFFFF, top_off, top_off));
        send_word(seg_word(KIND_POP, 16'h0000, '0, '0));
    endtask

    // Overflow the store, push two more segments at full, then drain it.
    task automatic run_fill();
        logic [63:0] pos;
        send_word(seg_word(KIND_CLEAR, 16'h0000, '0, '0));
        pos = 64'h100_0000_0000;
        repeat (STORE_DEPTH + 14) begin
            pos = pos - 64'd100;
            send_word(seg_word(KIND_PUSH, 16'hA5A5, pos[OFFSET_BITS-1:0], 48'd10));
        end
        send_word(seg_word(KIND_PUSH, 16'hA5A5, pos[OFFSET_BITS-1:0] - 48'd5, 48'd5));
        send_word(seg_word(KIND_PUSH, 16'hA5A5, '0, '0));
        repeat (STORE_DEPTH + 2)
            send_word(seg_word(KIND_POP, 16'h0000, '0, '0));
    endtask

    task automatic run_random(int unsigned n);
        t_in_item    w;
        int unsigned roll;
        logic [63:0] sz, fin, pos;
        repeat (n) begin
            roll = $urandom_range(99);
            if (seq_left == 0) begin
                gen_file   = gen_file - FILE_W'($urandom_range(1, 300));
                gen_cursor = 64'(rand_off() >> $urandom_range(1, 40)) + 64'd4096;
                seq_left   = $urandom_range(4, 40);
            end
            if (roll < 70) begin
                // well-formed: descending starts, ends near the previous start
                if ($urandom_range(15) == 0)
                    sz = 64'd0;
                else if ($urandom_range(7) == 0)
                    sz = 64'($urandom_range(1, 400));
                else
                    sz = 64'($urandom_range(1, 64));
                fin = gen_cursor + 64'($urandom_range(0, 16)) - 64'd8;
                pos = (fin > sz) ? fin - sz : 64'd0;
                w = seg_word(KIND_PUSH, gen_file, pos[OFFSET_BITS-1:0],
                             sz[OFFSET_BITS-1:0]);
                gen_cursor = pos;
                seq_left--;
                if (pos < 64'd128)
                    seq_left = 0;
            end else if (roll < 84) begin
                w = seg_word(KIND_POP, FILE_W'($urandom), rand_off(), rand_off());
            end else if (roll < 90) begin
                w = seg_word(KIND_PUSH, FILE_W'($urandom), rand_off(),
                             rand_off() >> $urandom_range(0, OFFSET_BITS - 1));
            end else if (roll < 93) begin
                w = seg_word(KIND_CLEAR, FILE_W'($urandom), rand_off(), rand_off());
            end else if (roll < 95) begin
                w = seg_word(KIND_UNUSED, FILE_W'($urandom), rand_off(), rand_off());
            end else begin
                // out of order: start above the cursor of the current group
                pos = gen_cursor + 64'($urandom_range(0, 200));
                w = seg_word(KIND_PUSH, gen_file, pos[OFFSET_BITS-1:0],
                             OFFSET_BITS'($urandom_range(0, 100)));
            end
            send_word(w);
        end
    endtask

    initial begin
        results       = new();
        i_rst_n       = 1'b0;
        seg_ch.valid  = 1'b0;
        seg_ch.data   = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        gen_file      = 16'hF000;
        gen_cursor    = 64'd0;
        seq_left      = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        run_directed();
        run_random(300);

        set_idling(52, 0);
        run_random(300);

        set_idling(0, 52);
        hold_len = 400;
        run_random(300);

        set_idling(17, 17);
        run_fill();
        run_random(200);

        seg_ch.valid <= 1'b0;
        // let the monitor note the last word before draining
        @(posedge i_clk);
        while (results.due_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (results.errors == 0)
            $display("io_segment_interval_merger_core test passed");
        else
            $display("io_segment_interval_merger_core test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("io_segment_interval_merger_core test failed");
        $finish;
    end

endmodule
